// File: src/fat12_cluster_chain_step_defines.svh
// Assertion macros for the FAT12 cluster chain step block
`ifndef FAT12_CLUSTER_CHAIN_STEP_DEFINES_SVH
`define FAT12_CLUSTER_CHAIN_STEP_DEFINES_SVH

// clocked property, masked during reset
`define FAT12CC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent holds, consequent follows in the next cycle
`define FAT12CC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/fat12cc_pkg.sv
`default_nettype none
package fat12cc_pkg;

  localparam int FAT12CC_TABLE_BYTES = 8192;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_RESERVED_SECTORS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FAT_SECTORS      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FAT_COPIES       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROOT_ENTRIES     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECTOR_LOG2      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLUSTER_SECTORS  = 3'd5;

  localparam logic [15:0] RESET_RESERVED_SECTORS = 16'd1;
  localparam logic [15:0] RESET_FAT_SECTORS      = 16'd9;
  localparam logic [7:0]  RESET_FAT_COPIES       = 8'd2;
  localparam logic [15:0] RESET_ROOT_ENTRIES     = 16'd224;
  localparam logic [3:0]  RESET_SECTOR_LOG2      = 4'd9;
  localparam logic [7:0]  RESET_CLUSTER_SECTORS  = 8'd1;

  localparam logic [3:0]  SECTOR_LOG2_MIN = 4'd7;
  localparam logic [3:0]  SECTOR_LOG2_MAX = 4'd12;
  localparam logic [11:0] FIRST_CLUSTER   = 12'd2;
  localparam logic [11:0] EOC_THRESHOLD   = 12'hFF8;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e        command;
    logic [12:0] table_address;
    logic [7:0]  table_byte;
    logic [11:0] cluster;
  } fat12cc_in_t;

  typedef struct packed {
    logic [31:0] sector_address;
    logic [11:0] next_cluster;
    logic        end_of_chain;
    logic        range_error;
  } fat12cc_out_t;

endpackage
`default_nettype wire

// File: src/fat12_cluster_chain_step.sv
// A query passes stage 1 (table read), then the output register. One item per
// cycle unless the output stalls; the table is two byte-interleaved banks, each
// with one write and one registered read port, so both entry bytes read at once.
// A table write gives no result. Reset clears the pipeline valids and loads the
// register defaults; table contents stay undefined until written (no clear pass).
`default_nettype none
`include "fat12_cluster_chain_step_defines.svh"
module fat12_cluster_chain_step
  import fat12cc_pkg::*;
#(
  parameter int TABLE_BYTES = FAT12CC_TABLE_BYTES
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                   in_valid_i,
  output      logic                   in_ready_o,
  input  wire fat12cc_in_t            in_data_i,
  output      logic                   out_valid_o,
  input  wire logic                   out_ready_i,
  output      fat12cc_out_t           out_data_o
);

  localparam int BankDepth = (TABLE_BYTES + 1) / 2;
  localparam int BankAw    = $clog2(BankDepth);

  // configuration registers
  logic [15:0] reserved_q, reserved_d;
  logic [15:0] fat_sec_q, fat_sec_d;
  logic [7:0]  copies_q, copies_d;
  logic [15:0] root_ent_q, root_ent_d;
  logic [3:0]  sec_log2_q, sec_log2_d;
  logic [7:0]  clus_sec_q, clus_sec_d;

  always_comb begin
    reserved_d = reserved_q;
    fat_sec_d  = fat_sec_q;
    copies_d   = copies_q;
    root_ent_d = root_ent_q;
    sec_log2_d = sec_log2_q;
    clus_sec_d = clus_sec_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_RESERVED_SECTORS: reserved_d = cfg_data_i;
        CFG_FAT_SECTORS:      fat_sec_d  = cfg_data_i;
        CFG_FAT_COPIES:       copies_d   = cfg_data_i[7:0];
        CFG_ROOT_ENTRIES:     root_ent_d = cfg_data_i;
        CFG_SECTOR_LOG2:      sec_log2_d = cfg_data_i[3:0];
        CFG_CLUSTER_SECTORS:  clus_sec_d = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q <= RESET_RESERVED_SECTORS;
      fat_sec_q  <= RESET_FAT_SECTORS;
      copies_q   <= RESET_FAT_COPIES;
      root_ent_q <= RESET_ROOT_ENTRIES;
      sec_log2_q <= RESET_SECTOR_LOG2;
      clus_sec_q <= RESET_CLUSTER_SECTORS;
    end else begin
      reserved_q <= reserved_d;
      fat_sec_q  <= fat_sec_d;
      copies_q   <= copies_d;
      root_ent_q <= root_ent_d;
      sec_log2_q <= sec_log2_d;
      clus_sec_q <= clus_sec_d;
    end
  end

  // handshake
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic s1_adv;
  logic in_accept;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_accept  = in_valid_i && in_ready_o;

  // stage 0: address decode, range check, cluster offset
  logic [11:0] cl;
  logic [12:0] idx;
  logic [11:0] idx_half;
  logic        err0;
  logic        wr_en;
  logic        rd_en;
  logic        wr_in_range;
  logic [BankAw-1:0] wr_addr;
  logic [BankAw-1:0] even_raddr;
  logic [BankAw-1:0] odd_raddr;
  logic [11:0] cl_m2;

  assign cl          = in_data_i.cluster;
  assign idx         = 13'(cl) + 13'(cl >> 1);
  assign idx_half    = idx[12:1];
  assign err0        = (cl < FIRST_CLUSTER) || ((32'(idx) + 32'd1) >= 32'(TABLE_BYTES));
  assign wr_in_range = 32'(in_data_i.table_address) < 32'(TABLE_BYTES);
  assign wr_en       = in_accept && (in_data_i.command == CMD_WRITE) && wr_in_range;
  assign rd_en       = in_accept && (in_data_i.command == CMD_QUERY) && !err0;
  assign wr_addr     = BankAw'(in_data_i.table_address[12:1]);
  assign even_raddr  = BankAw'(13'(idx_half) + 13'(idx[0]));
  assign odd_raddr   = BankAw'(idx_half);
  assign cl_m2       = cl - FIRST_CLUSTER;

  logic [7:0] even_mem [BankDepth];
  logic [7:0] odd_mem  [BankDepth];
  logic [7:0] even_rd_q;
  logic [7:0] odd_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en && !in_data_i.table_address[0]) begin
      even_mem[wr_addr] <= in_data_i.table_byte;
    end
    if (rd_en) begin
      even_rd_q <= even_mem[even_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && in_data_i.table_address[0]) begin
      odd_mem[wr_addr] <= in_data_i.table_byte;
    end
    if (rd_en) begin
      odd_rd_q <= odd_mem[odd_raddr];
    end
  end

  // stage 1 payload
  logic        s1_err_q;
  logic        s1_odd_q;
  logic        s1_swap_q;
  logic [19:0] s1_off_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_err_q  <= err0;
      s1_odd_q  <= cl[0];
      s1_swap_q <= idx[0];
      s1_off_q  <= 20'(cl_m2) * 20'(clus_sec_q);
    end
  end

  assign s1_valid_d = in_ready_o ? (in_accept && (in_data_i.command == CMD_QUERY)) : s1_valid_q;

  // stage 1: entry unpack and sector address
  logic [3:0]   lg_sat;
  logic [20:0]  root_bytes;
  logic [21:0]  root_round;
  logic [14:0]  root_sec;
  logic [23:0]  fat_total;
  logic [31:0]  sec_addr;
  logic [15:0]  word;
  logic [11:0]  next_cl;
  fat12cc_out_t out_q, out_d;

  always_comb begin
    if (sec_log2_q < SECTOR_LOG2_MIN) begin
      lg_sat = SECTOR_LOG2_MIN;
    end else if (sec_log2_q > SECTOR_LOG2_MAX) begin
      lg_sat = SECTOR_LOG2_MAX;
    end else begin
      lg_sat = sec_log2_q;
    end
    root_bytes = {root_ent_q, 5'b0};
    root_round = 22'(root_bytes) + ((22'd1 << lg_sat) - 22'd1);
    root_sec   = 15'(root_round >> lg_sat);
    fat_total  = 24'(copies_q) * 24'(fat_sec_q);
    sec_addr   = 32'(reserved_q) + 32'(fat_total) + 32'(root_sec) + 32'(s1_off_q);
    word       = s1_swap_q ? {even_rd_q, odd_rd_q} : {odd_rd_q, even_rd_q};
    next_cl    = s1_odd_q ? word[15:4] : word[11:0];
    if (s1_err_q) begin
      out_d.sector_address = '0;
      out_d.next_cluster   = '0;
      out_d.end_of_chain   = 1'b0;
      out_d.range_error    = 1'b1;
    end else begin
      out_d.sector_address = sec_addr;
      out_d.next_cluster   = next_cl;
      out_d.end_of_chain   = next_cl >= EOC_THRESHOLD;
      out_d.range_error    = 1'b0;
    end
  end

  assign out_valid_d = s1_adv ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `FAT12CC_ASSERT_NEXT(a_s1_holds, s1_valid_q && !s1_adv, s1_valid_q, "stalled query lost")
  `FAT12CC_ASSERT(a_ready_full, !in_ready_o |-> (s1_valid_q && out_valid_q), "spurious stall")
  `FAT12CC_ASSERT(a_eoc_err, out_valid_q |-> !(out_q.end_of_chain && out_q.range_error), "eoc on error")

endmodule
`default_nettype wire

// File: dv/tb_fat12_cluster_chain_step.sv
import fat12cc_pkg::*;

class chain_step_checker;
  logic [7:0]   table_mirror [FAT12CC_TABLE_BYTES];
  logic [15:0]  rsv_secs;
  logic [15:0]  fat_secs;
  logic [7:0]   fat_copies;
  logic [15:0]  root_ents;
  logic [3:0]   sec_log2;
  logic [7:0]   clus_secs;
  fat12cc_out_t expected_steps [$];
  int unsigned  errors;

  function new();
    rsv_secs   = RESET_RESERVED_SECTORS;
    fat_secs   = RESET_FAT_SECTORS;
    fat_copies = RESET_FAT_COPIES;
    root_ents  = RESET_ROOT_ENTRIES;
    sec_log2   = RESET_SECTOR_LOG2;
    clus_secs  = RESET_CLUSTER_SECTORS;
    errors     = 0;
  endfunction

  function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_RESERVED_SECTORS: rsv_secs   = val;
      CFG_FAT_SECTORS:      fat_secs   = val;
      CFG_FAT_COPIES:       fat_copies = val[7:0];
      CFG_ROOT_ENTRIES:     root_ents  = val;
      CFG_SECTOR_LOG2:      sec_log2   = val[3:0];
      CFG_CLUSTER_SECTORS:  clus_secs  = val[7:0];
      default: ;
    endcase
  endfunction

  function void note_item(fat12cc_in_t it);
    fat12cc_out_t r;
    int unsigned  ix;
    int unsigned  lg;
    int unsigned  root_secs;
    int unsigned  start;
    logic [15:0]  word;
    logic [11:0]  nxt;
    if (it.command == CMD_WRITE) begin
      if (32'(it.table_address) < FAT12CC_TABLE_BYTES)
        table_mirror[it.table_address] = it.table_byte;
      return;
    end
    r  = '0;
    ix = 32'(it.cluster) * 32'd3 / 32'd2;
    if (it.cluster < FIRST_CLUSTER || ix + 1 >= FAT12CC_TABLE_BYTES) begin
      r.range_error = 1'b1;
    end else begin
      lg = sec_log2;
      if (lg < SECTOR_LOG2_MIN) lg = SECTOR_LOG2_MIN;
      if (lg > SECTOR_LOG2_MAX) lg = SECTOR_LOG2_MAX;
      root_secs = (32'(root_ents) * 32'd32 + (32'd1 << lg) - 32'd1) >> lg;
      start = 32'(rsv_secs) + 32'(fat_copies) * 32'(fat_secs) + root_secs;
      r.sector_address = start + (32'(it.cluster) - 32'd2) * 32'(clus_secs);
      word = {table_mirror[ix+1], table_mirror[ix]};
      nxt  = it.cluster[0] ? word[15:4] : word[11:0];
      r.next_cluster = nxt;
      r.end_of_chain = (nxt >= EOC_THRESHOLD);
    end
    expected_steps.push_back(r);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  function void check_step(fat12cc_out_t got);
    fat12cc_out_t want;
    if (expected_steps.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      return;
    end
    want = expected_steps.pop_front();
    compare_field("sector_address", want.sector_address, got.sector_address);
    compare_field("next_cluster", 32'(want.next_cluster), 32'(got.next_cluster));
    compare_field("end_of_chain", 32'(want.end_of_chain), 32'(got.end_of_chain));
    compare_field("range_error", 32'(want.range_error), 32'(got.range_error));
  endfunction
endclass

module tb_fat12_cluster_chain_step;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 255;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we      = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;
  logic                   in_valid    = 1'b0;
  logic                   in_ready_o;
  fat12cc_in_t            in_data     = '0;
  logic                   out_valid_o;
  logic                   out_ready   = 1'b0;
  fat12cc_out_t           out_data_o;

  chain_step_checker      sb;
  int unsigned            src_idle_pct  = 38;
  int unsigned            sink_idle_pct = 68;
  int unsigned            items_sent    = 0;
  int unsigned            stall_cycles  = 0;
  logic [7:0]             shadow_tbl [FAT12CC_TABLE_BYTES];
  bit                     shadow_set [FAT12CC_TABLE_BYTES];

  fat12_cluster_chain_step dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) sb.note_item(in_data);
      if (out_valid_o && out_ready) sb.check_step(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic push_item(input fat12cc_in_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic put_byte(input int unsigned addr, input logic [7:0] val);
    fat12cc_in_t it;
    it.command       = CMD_WRITE;
    it.table_address = 13'(addr);
    it.table_byte    = val;
    it.cluster       = 12'($urandom());
    push_item(it);
    shadow_tbl[addr] = val;
    shadow_set[addr] = 1'b1;
  endtask

  task automatic put_entry(input int unsigned c, input logic [11:0] v);
    int unsigned ix;
    logic [7:0]  b0;
    logic [7:0]  b1;
    ix = c * 3 / 2;
    b0 = shadow_set[ix] ? shadow_tbl[ix] : 8'($urandom());
    b1 = shadow_set[ix+1] ? shadow_tbl[ix+1] : 8'($urandom());
    if ((c & 1) == 0) begin
      b0 = v[7:0];
      b1 = {b1[7:4], v[11:8]};
    end else begin
      b0 = {v[3:0], b0[3:0]};
      b1 = v[11:4];
    end
    put_byte(ix, b0);
    put_byte(ix + 1, b1);
  endtask

  function automatic bit entry_ready(int unsigned c);
    int unsigned ix;
    ix = c * 3 / 2;
    return c >= 2 && shadow_set[ix] && shadow_set[ix+1];
  endfunction

  function automatic int unsigned shadow_entry(int unsigned c);
    int unsigned ix;
    logic [15:0] word;
    ix   = c * 3 / 2;
    word = {shadow_tbl[ix+1], shadow_tbl[ix]};
    return ((c & 1) == 0) ? 32'(word[11:0]) : 32'(word[15:4]);
  endfunction

  task automatic ask(input int unsigned c);
    fat12cc_in_t it;
    it.command       = CMD_QUERY;
    it.table_address = 13'($urandom());
    it.table_byte    = 8'($urandom());
    it.cluster       = 12'(c);
    push_item(it);
  endtask

  // follow the chain as a host would, stopping at end of chain or unloaded entries
  task automatic walk(input int unsigned c);
    for (int n = 0; n < 10; n++) begin
      if (c >= 2 && !entry_ready(c)) break;
      ask(c);
      if (c < 2) break;
      c = shadow_entry(c);
      if (c >= EOC_THRESHOLD) break;
    end
  endtask

  task automatic build_chain(input bit broken);
    int unsigned links [$];
    int unsigned len;
    int unsigned c;
    logic [11:0] tail;
    len = $urandom_range(1, 6);
    c   = $urandom_range(2, 4095);
    for (int i = 0; i < len; i++) begin
      links.push_back(c);
      c = ($urandom_range(2) == 0 && c < 4095) ? c + 1 : $urandom_range(2, 4095);
    end
    case ($urandom_range(3))
      0: tail = EOC_THRESHOLD + 12'($urandom_range(7));
      1: tail = 12'($urandom_range(1));
      2: tail = 12'($urandom());
      default: tail = 12'hFFF;
    endcase
    for (int i = 0; i < len; i++)
      put_entry(links[i], (i + 1 < len) ? 12'(links[i+1]) : tail);
    if (broken)
      put_byte(links[$urandom_range(len - 1)] * 3 / 2 + $urandom_range(1), 8'($urandom()));
    walk(links[0]);
  endtask

  task automatic random_action();
    int unsigned roll;
    int unsigned c;
    roll = $urandom_range(99);
    if (roll < 45) begin
      build_chain(1'b0);
    end else if (roll < 55) begin
      build_chain(1'b1);
    end else if (roll < 75) begin
      c = $urandom_range(4095);
      if (c >= 2 && !entry_ready(c)) put_entry(c, 12'($urandom()));
      ask(c);
    end else if (roll < 90) begin
      put_byte($urandom_range(FAT12CC_TABLE_BYTES - 1), 8'($urandom()));
    end else begin
      ask($urandom_range(1));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_steps.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic apply_config(input int p);
    logic [15:0] v [6];
    case (p)
      0: v = '{16'hFFFF, 16'hFFFF, 16'h00FF, 16'hFFFF, 16'd12, 16'h00FF};
      1: v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd7, 16'd0};
      2: v = '{16'($urandom()), 16'($urandom()), 16'($urandom_range(255)),
               16'($urandom()), 16'($urandom_range(6)), 16'($urandom_range(1, 255))};
      3: v = '{16'($urandom()), 16'($urandom()), 16'($urandom_range(255)),
               16'($urandom()), 16'($urandom_range(13, 15)), 16'($urandom_range(255))};
      4: v = '{16'($urandom()), 16'($urandom()), 16'($urandom_range(255)),
               16'($urandom()), 16'($urandom_range(15)), 16'($urandom_range(255))};
      default: v = '{RESET_RESERVED_SECTORS, RESET_FAT_SECTORS, 16'(RESET_FAT_COPIES),
                     RESET_ROOT_ENTRIES, 16'(RESET_SECTOR_LOG2),
                     16'(RESET_CLUSTER_SECTORS)};
    endcase
    write_reg(CFG_RESERVED_SECTORS, v[0]);
    write_reg(CFG_FAT_SECTORS, v[1]);
    write_reg(CFG_FAT_COPIES, v[2]);
    write_reg(CFG_ROOT_ENTRIES, v[3]);
    write_reg(CFG_SECTOR_LOG2, v[4]);
    write_reg(CFG_CLUSTER_SECTORS, v[5]);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned stop_at;
    sb = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset configuration: range errors, nibble packing, table extremes
    ask(0);
    ask(1);
    put_entry(2, 12'h003);
    put_entry(3, 12'hFF8);
    put_entry(4094, 12'hFF7);
    put_entry(4095, 12'h000);
    put_byte(FAT12CC_TABLE_BYTES - 1, 8'hFF);
    put_byte(4096, 8'h00);
    ask(2);
    ask(3);
    ask(4094);
    ask(4095);
    put_entry(4, 12'hFFF);
    ask(4);

    for (int p = 0; p < 6; p++) begin
      drain();
      src_idle_pct  = (p < 2) ? 38 : (p < 4) ? 68 : 0;
      sink_idle_pct = (p < 2) ? 68 : (p < 4) ? 38 : 0;
      apply_config(p);
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) random_action();
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+src
src/fat12cc_pkg.sv
src/fat12_cluster_chain_step.sv
dv/tb_fat12_cluster_chain_step.sv
